// ----- rtl/core/wvqe_pkg.sv -----
// Shared constants, types and command structs of the windowed variance quote engine.
package wvqe_pkg;

	localparam int WINDOW_MAX = 1024;
	localparam int SLOT_W     = $clog2(WINDOW_MAX);
	localparam int CNT_W      = SLOT_W + 1;

	localparam int PRICE_W  = 24;
	localparam int POS_W    = 16;
	localparam int HOR_W    = 24;
	localparam int GAMMA_W  = 24;
	localparam int BASE_W   = 24;
	localparam int RES_W    = 32;
	localparam int SPREAD_W = 24;
	localparam int VOL_W    = 24;

	localparam int SUM_W  = PRICE_W + SLOT_W;
	localparam int SQ_W   = 2 * PRICE_W + SLOT_W;
	localparam int NUM_W  = SQ_W + CNT_W;
	localparam int DEN_W  = 2 * SLOT_W;
	localparam int VAR_W  = 2 * PRICE_W;
	localparam int ROOT_W = VAR_W / 2;
	localparam int SREM_W = ROOT_W + 1;
	localparam int GH_W   = GAMMA_W + HOR_W;
	localparam int P_W    = GH_W + VAR_W;

	localparam int MA_W      = P_W;
	localparam int MB_W      = GH_W;
	localparam int MACC_W    = P_W + POS_W;
	localparam int DIGIT_W   = 8;
	localparam int MUL_STEPS = MB_W / DIGIT_W;
	localparam int DIV_STEPS = NUM_W;
	localparam int SQRT_STEPS = VAR_W / 2;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam int FRAC_SHIFT = 36;
	localparam int MAG_W      = 35;
	localparam logic [MAG_W-1:0] MAG_CLAMP = MAG_W'(64'h4_0000_0000);
	localparam logic [VAR_W-1:0] VAR_FLOOR = VAR_W'(1678);

	// reservation price before saturation and its int32 limits
	localparam int RS_W = MAG_W + 2;
	localparam logic signed [RS_W-1:0] RS_MAX = RS_W'(64'sd2147483647);
	localparam logic signed [RS_W-1:0] RS_MIN = -RS_W'(64'sd2147483648);

	// floor(mid / 200) = floor(floor(mid / 8) / 25), the last by reciprocal
	localparam int CAP_PRE   = 3;
	localparam int CAP_X_W   = PRICE_W - CAP_PRE;
	localparam int CAP_M_W   = 22;
	localparam int CAP_SHIFT = 26;
	localparam logic [CAP_M_W-1:0] CAP_RECIP = CAP_M_W'(2684355);
	localparam int CAP_W     = CAP_X_W + CAP_M_W - CAP_SHIFT;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RISK_AVERSION = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPREAD_BASE   = 2'd2;

	localparam logic [CNT_W-1:0]   WLEN_RESET  = CNT_W'(100);
	localparam logic [GAMMA_W-1:0] GAMMA_RESET = GAMMA_W'(6554);
	localparam logic [BASE_W-1:0]  BASE_RESET  = BASE_W'(41);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_UPDATE,
		ST_MLOAD,
		ST_MRUN,
		ST_MSTORE,
		ST_DLOAD,
		ST_DRUN,
		ST_SLOAD,
		ST_SRUN,
		ST_FINISH
	} qe_state_t;

	typedef enum logic [2:0] {
		MUL_NQ,
		MUL_SS,
		MUL_DEN,
		MUL_GH,
		MUL_GHV,
		MUL_POS
	} mul_op_t;

	typedef struct packed {
		logic    accept;
		logic    square;
		logic    update;
		logic    mul_load;
		logic    mul_step;
		logic    mul_store;
		mul_op_t mul_op;
		logic    div_load;
		logic    div_step;
		logic    sqrt_load;
		logic    sqrt_step;
		logic    out_load;
	} qe_cmd_t;

	typedef struct packed {
		logic out_pending;
	} qe_status_t;

endpackage

// ----- rtl/core/wvqe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module wvqe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/wvqe_ctrl.sv -----
// Sequencer of the quote engine: walks one tick through update, multiplies, divide and root.
module wvqe_ctrl import wvqe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  qe_status_t status,
	output qe_cmd_t    cmd
);

	qe_state_t         state_q, state_d;
	mul_op_t           op_q, op_d;
	logic [STEP_W-1:0] step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= MUL_NQ;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		op_d     = op_q;
		step_d   = step_q;
		cmd      = '0;
		cmd.mul_op = op_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_SQUARE;
				end
			end
			ST_SQUARE: begin
				cmd.square = 1'b1;
				state_d    = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				op_d       = MUL_NQ;
				state_d    = ST_MLOAD;
			end
			ST_MLOAD: begin
				cmd.mul_load = 1'b1;
				step_d       = '0;
				state_d      = ST_MRUN;
			end
			ST_MRUN: begin
				cmd.mul_step = 1'b1;
				if (step_q == STEP_W'(MUL_STEPS - 1)) begin
					step_d  = '0;
					state_d = ST_MSTORE;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_MSTORE: begin
				cmd.mul_store = 1'b1;
				unique case (op_q)
					MUL_NQ: begin
						op_d    = MUL_SS;
						state_d = ST_MLOAD;
					end
					MUL_SS: begin
						op_d    = MUL_DEN;
						state_d = ST_MLOAD;
					end
					MUL_DEN: state_d = ST_DLOAD;
					MUL_GH: begin
						op_d    = MUL_GHV;
						state_d = ST_MLOAD;
					end
					MUL_GHV: begin
						op_d    = MUL_POS;
						state_d = ST_MLOAD;
					end
					MUL_POS: state_d = ST_FINISH;
					default: state_d = ST_FINISH;
				endcase
			end
			ST_DLOAD: begin
				cmd.div_load = 1'b1;
				step_d       = '0;
				state_d      = ST_DRUN;
			end
			ST_DRUN: begin
				cmd.div_step = 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					step_d  = '0;
					state_d = ST_SLOAD;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_SLOAD: begin
				cmd.sqrt_load = 1'b1;
				step_d        = '0;
				state_d       = ST_SRUN;
			end
			ST_SRUN: begin
				cmd.sqrt_step = 1'b1;
				if (step_q == STEP_W'(SQRT_STEPS - 1)) begin
					step_d  = '0;
					op_d    = MUL_GH;
					state_d = ST_MLOAD;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_FINISH: begin
				// hold until the output register is free
				if (!status.out_pending) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- rtl/core/wvqe_datapath.sv -----
// Datapath of the quote engine: price ring, running sums, shared multiplier, divider, root.
module wvqe_datapath import wvqe_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic [PRICE_W-1:0]         mid_px,
	input  logic signed [POS_W-1:0]    position,
	input  logic [HOR_W-1:0]           horizon,
	input  qe_cmd_t                    cmd,
	output qe_status_t                 status,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic signed [RES_W-1:0]    reserve_px,
	output logic [SPREAD_W-1:0]        quote_spread,
	output logic [VOL_W-1:0]           volatility
);

	logic [CNT_W-1:0]   wlen_q;
	logic [GAMMA_W-1:0] gamma_q;
	logic [BASE_W-1:0]  base_q;

	logic [CNT_W-1:0]  fill_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SQ_W-1:0]   sq_q;

	logic [PRICE_W-1:0]      mid_q;
	logic signed [POS_W-1:0] pos_q;
	logic [HOR_W-1:0]        hor_q;
	logic [PRICE_W-1:0]      old_price;
	logic [VAR_W-1:0]        old_sq_q, mid_sq_q;

	logic [MA_W-1:0]   ma_q, ma_d;
	logic [MB_W-1:0]   mb_q, mb_d;
	logic [MACC_W-1:0] acc_q;
	logic [MA_W+DIGIT_W-1:0] pp;

	logic [NUM_W-1:0] nq_q, num_q, quo_q;
	logic [DEN_W-1:0] den_q, rem_q;
	logic [DEN_W:0]   rem_sh;
	logic             rem_ge;
	logic [GH_W-1:0]  gh_q;
	logic [P_W-1:0]   p_q;
	logic [MAG_W-1:0] mag_q;

	logic [VAR_W-1:0]  var_q, rad_q, fvar;
	logic [ROOT_W-1:0] root_q;
	logic [SREM_W-1:0] srem_q;
	logic [SREM_W+1:0] s_t, s_trial;
	logic              s_ge;

	logic [CNT_W-1:0]  len_eff, slot_inc;
	logic              full;
	logic [POS_W-1:0]  abs_pos;

	logic [P_W-FRAC_SHIFT:0]      ssum;
	logic [CAP_X_W+CAP_M_W-1:0]   cap_p;
	logic [CAP_W-1:0]             cap;
	logic [SPREAD_W-1:0]          spread;
	logic signed [RS_W-1:0]       rs;
	logic signed [RES_W-1:0]      res;

	logic                     ovalid_q;
	logic signed [RES_W-1:0]  res_q;
	logic [SPREAD_W-1:0]      spread_q;
	logic [VOL_W-1:0]         vol_q;

	wvqe_ram #(.WIDTH(PRICE_W), .DEPTH(WINDOW_MAX)) u_ring (
		.clk   (clk),
		.we    (cmd.update),
		.waddr (slot_q),
		.wdata (mid_q),
		.re    (cmd.accept),
		.raddr (slot_q),
		.rdata (old_price)
	);

	always_comb begin
		if (wlen_q < CNT_W'(2)) begin
			len_eff = CNT_W'(2);
		end else if (wlen_q > CNT_W'(WINDOW_MAX)) begin
			len_eff = CNT_W'(WINDOW_MAX);
		end else begin
			len_eff = wlen_q;
		end
	end

	assign full     = fill_q >= len_eff;
	assign slot_inc = {1'b0, slot_q} + 1'b1;
	assign abs_pos  = pos_q[POS_W-1] ? POS_W'(-pos_q) : POS_W'(pos_q);
	assign fvar     = (var_q < VAR_FLOOR) ? VAR_FLOOR : var_q;

	// config registers and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q  <= WLEN_RESET;
			gamma_q <= GAMMA_RESET;
			base_q  <= BASE_RESET;
			fill_q  <= '0;
			slot_q  <= '0;
			sum_q   <= '0;
			sq_q    <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_WINDOW_LENGTH: begin
					wlen_q <= cfg_data[CNT_W-1:0];
					fill_q <= '0;
					slot_q <= '0;
					sum_q  <= '0;
					sq_q   <= '0;
				end
				REG_RISK_AVERSION: gamma_q <= cfg_data[GAMMA_W-1:0];
				REG_SPREAD_BASE:   base_q  <= cfg_data[BASE_W-1:0];
				default: ;
			endcase
		end else if (cmd.update) begin
			if (full) begin
				sum_q <= sum_q - SUM_W'(old_price) + SUM_W'(mid_q);
				sq_q  <= sq_q - SQ_W'(old_sq_q) + SQ_W'(mid_sq_q);
			end else begin
				fill_q <= fill_q + 1'b1;
				sum_q  <= sum_q + SUM_W'(mid_q);
				sq_q   <= sq_q + SQ_W'(mid_sq_q);
			end
			slot_q <= (slot_inc >= len_eff) ? '0 : slot_inc[SLOT_W-1:0];
		end
	end

	always_comb begin
		ma_d = '0;
		mb_d = '0;
		case (cmd.mul_op)
			MUL_NQ: begin
				ma_d = MA_W'(sq_q);
				mb_d = MB_W'(fill_q);
			end
			MUL_SS: begin
				ma_d = MA_W'(sum_q);
				mb_d = MB_W'(sum_q);
			end
			MUL_DEN: begin
				ma_d = MA_W'(fill_q);
				mb_d = MB_W'(fill_q - 1'b1);
			end
			MUL_GH: begin
				ma_d = MA_W'(gamma_q);
				mb_d = MB_W'(hor_q);
			end
			MUL_GHV: begin
				ma_d = MA_W'(fvar);
				mb_d = MB_W'(gh_q);
			end
			MUL_POS: begin
				ma_d = MA_W'(p_q);
				mb_d = MB_W'(abs_pos);
			end
			default: ;
		endcase
	end

	assign pp = ma_q * mb_q[MB_W-1 -: DIGIT_W];

	assign rem_sh  = {rem_q, quo_q[NUM_W-1]};
	assign rem_ge  = rem_sh >= {1'b0, den_q};
	assign s_t     = {srem_q, rad_q[VAR_W-1 -: 2]};
	assign s_trial = (SREM_W + 2)'({root_q, 2'b01});
	assign s_ge    = s_t >= s_trial;

	// tick payload and arithmetic units
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mid_q <= mid_px;
			pos_q <= position;
			hor_q <= horizon;
		end
		if (cmd.square) begin
			old_sq_q <= old_price * old_price;
			mid_sq_q <= mid_q * mid_q;
		end
		if (cmd.mul_load) begin
			ma_q  <= ma_d;
			mb_q  <= mb_d;
			acc_q <= '0;
		end else if (cmd.mul_step) begin
			acc_q <= (acc_q << DIGIT_W) + MACC_W'(pp);
			mb_q  <= mb_q << DIGIT_W;
		end
		if (cmd.mul_store) begin
			case (cmd.mul_op)
				MUL_NQ:  nq_q  <= acc_q[NUM_W-1:0];
				MUL_SS:  num_q <= nq_q - acc_q[NUM_W-1:0];
				MUL_DEN: den_q <= acc_q[DEN_W-1:0];
				MUL_GH:  gh_q  <= acc_q[GH_W-1:0];
				MUL_GHV: p_q   <= acc_q[P_W-1:0];
				MUL_POS: begin
					if ((|acc_q[MACC_W-1:FRAC_SHIFT+MAG_W])
							|| (acc_q[FRAC_SHIFT+MAG_W-1:FRAC_SHIFT] > MAG_CLAMP)) begin
						mag_q <= MAG_CLAMP;
					end else begin
						mag_q <= acc_q[FRAC_SHIFT+MAG_W-1:FRAC_SHIFT];
					end
				end
				default: ;
			endcase
		end
		if (cmd.div_load) begin
			rem_q <= '0;
			quo_q <= num_q;
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], rem_ge};
		end
		if (cmd.sqrt_load) begin
			// variance is zero below two samples
			var_q  <= (fill_q >= CNT_W'(2)) ? quo_q[VAR_W-1:0] : '0;
			rad_q  <= (fill_q >= CNT_W'(2)) ? quo_q[VAR_W-1:0] : '0;
			root_q <= '0;
			srem_q <= '0;
		end else if (cmd.sqrt_step) begin
			rad_q <= rad_q << 2;
			if (s_ge) begin
				srem_q <= SREM_W'(s_t - s_trial);
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				srem_q <= s_t[SREM_W-1:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	// final spread cap and reservation price
	assign ssum  = {1'b0, p_q[P_W-1:FRAC_SHIFT]} + (P_W - FRAC_SHIFT + 1)'(base_q);
	assign cap_p = mid_q[PRICE_W-1:CAP_PRE] * CAP_RECIP;
	assign cap   = cap_p[CAP_X_W+CAP_M_W-1:CAP_SHIFT];
	assign spread = (ssum > (P_W - FRAC_SHIFT + 1)'(cap)) ? SPREAD_W'(cap)
		: ssum[SPREAD_W-1:0];
	assign rs = pos_q[POS_W-1]
		? $signed(RS_W'(mid_q)) + $signed(RS_W'(mag_q))
		: $signed(RS_W'(mid_q)) - $signed(RS_W'(mag_q));

	always_comb begin
		if (rs > RS_MAX) begin
			res = RES_W'(RS_MAX);
		end else if (rs < RS_MIN) begin
			res = RES_W'(RS_MIN);
		end else begin
			res = rs[RES_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q    <= res;
			spread_q <= spread;
			vol_q    <= root_q;
		end
	end

	assign status.out_pending = ovalid_q && !out_ready;
	assign out_valid          = ovalid_q;
	assign reserve_px         = res_q;
	assign quote_spread       = spread_q;
	assign volatility         = vol_q;

endmodule

// ----- rtl/core/windowed_variance_quote_engine_core.sv -----
// Top level of the windowed variance quote engine.
//
// One tick in, one quote out. Each transfer on the input channel pushes the mid price
// into a ring of the last window_length prices (1024-entry RAM), updates a running sum
// and sum of squares, then forms the sample variance, the volatility (its square root),
// the inventory-skewed reservation price and the capped spread. A tick runs from its input
// transfer to a loaded result, and the next tick is taken in the cycle after that result
// is loaded, so the block holds one tick at a time. The sequencer steps through the ring
// update (square, then write), six multiplies on one shared 96x8 digit multiplier, a 69-step
// restoring divider for the sample variance and a 24-step digit-by-digit square
// root. The output register holds a finished quote while the next tick is accepted; the
// engine only stalls in its last cycle if a quote is still waiting there. Writes to
// window_length empty the window; configure only while no tick is in flight.
module windowed_variance_quote_engine_core import wvqe_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [PRICE_W-1:0]      mid_px,
	input  logic signed [POS_W-1:0] position,
	input  logic [HOR_W-1:0]        horizon,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [RES_W-1:0] reserve_px,
	output logic [SPREAD_W-1:0]     quote_spread,
	output logic [VOL_W-1:0]        volatility
);

	// command and status between sequencer and datapath
	qe_cmd_t    cmd;
	qe_status_t status;

	wvqe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	wvqe_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mid_px       (mid_px),
		.position     (position),
		.horizon      (horizon),
		.cmd          (cmd),
		.status       (status),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.reserve_px   (reserve_px),
		.quote_spread (quote_spread),
		.volatility   (volatility)
	);

endmodule

// ----- rtl/core/wvqe_checker.sv -----
// Port-level checks of the quote engine, bound to the top level.
module wvqe_checker import wvqe_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [RES_W-1:0] reserve_px,
	input logic [SPREAD_W-1:0]     quote_spread,
	input logic [VOL_W-1:0]        volatility
);

	// hold a stalled quote
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("quote dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(reserve_px) && $stable(quote_spread)
			&& $stable(volatility))
		else $error("stalled quote changed");

	// one tick at a time: input closes right after a transfer
	a_one_tick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second tick taken while busy");

	// spread never exceeds half a percent of the largest mid price
	a_spread_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> quote_spread <= SPREAD_W'(83886))
		else $error("spread above cap");

endmodule

bind windowed_variance_quote_engine_core wvqe_checker u_wvqe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.reserve_px   (reserve_px),
	.quote_spread (quote_spread),
	.volatility   (volatility)
);
